FILE: hw/rtl/ktr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktr_pkg: shared types and constants of the typematic repeat core
// Payload structs, key phase codes, command codes and register indexes.
// ----------------------------------------------------------------------------
package ktr_pkg;

    localparam int unsigned NUM_KEYS_DEFAULT = 13;

    localparam int unsigned KEY_LEVELS_W = 13;
    localparam int unsigned KEY_INDEX_W  = 4;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned DELAY_W      = 16;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_ONLY_MASK  = 2'd2;

    localparam logic [DELAY_W-1:0]      INITIAL_DELAY_RESET   = 16'd250;
    localparam logic [DELAY_W-1:0]      REPEAT_INTERVAL_RESET = 16'd33;
    localparam logic [KEY_LEVELS_W-1:0] EDGE_ONLY_MASK_RESET  = '0;

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        PH_UNPRESSED = 2'd0,
        PH_PRESSED   = 2'd1,
        PH_HOLD      = 2'd2,
        PH_RELEASED  = 2'd3
    } ktr_phase_t;

    typedef struct packed {
        logic                    command;
        logic [KEY_LEVELS_W-1:0] key_levels;
        logic [KEY_INDEX_W-1:0]  key_index;
        logic [TIME_W-1:0]       now_ms;
    } ktr_in_t;

    typedef struct packed {
        logic       key_active;
        logic [1:0] key_phase;
    } ktr_out_t;

    // Per-key control from the top level to one key cell.
    typedef struct packed {
        logic poll;
        logic query;
        logic level;
        logic edge_only;
    } ktr_key_ctrl_t;

    // Per-key status from one key cell back to the top level.
    typedef struct packed {
        ktr_phase_t phase;
        logic       fire;
    } ktr_key_stat_t;

endpackage

FILE: hw/rtl/ktr_key_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktr_key_cell: state of one key
// Holds the phase, time stamp and repeat flag of a single key and applies
// poll and query updates to them.
// ----------------------------------------------------------------------------
module ktr_key_cell import ktr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ktr_key_ctrl_t       ctrl,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [DELAY_W-1:0]  initial_delay,
    input  logic [DELAY_W-1:0]  repeat_interval,
    output ktr_key_stat_t       stat
);

    ktr_phase_t         phase_reg, phase_next;
    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic               repeating_reg, repeating_next;

    logic [TIME_W-1:0]  elapsed;
    logic [DELAY_W-1:0] armed_delay;
    logic               hold_due;
    logic               hold_fire;

    // Elapsed time wraps modulo 2^32, so a plain subtraction is correct.
    assign elapsed     = now_ms - stamp_reg;
    assign armed_delay = repeating_reg ? repeat_interval : initial_delay;
    assign hold_due    = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, armed_delay};
    assign hold_fire   = (phase_reg == PH_HOLD) && !ctrl.edge_only && hold_due;

    assign stat.phase = phase_reg;
    assign stat.fire  = (phase_reg == PH_PRESSED) || hold_fire;

    always_comb begin
        phase_next     = phase_reg;
        stamp_next     = stamp_reg;
        repeating_next = repeating_reg;
        if (ctrl.poll) begin
            if (ctrl.level) begin
                case (phase_reg)
                    PH_UNPRESSED: begin
                        phase_next     = PH_PRESSED;
                        stamp_next     = now_ms;
                        repeating_next = 1'b0;
                    end
                    default: begin
                        phase_next = PH_HOLD;
                    end
                endcase
            end else begin
                case (phase_reg)
                    PH_PRESSED, PH_HOLD: begin
                        phase_next = PH_RELEASED;
                    end
                    default: begin
                        phase_next = PH_UNPRESSED;
                    end
                endcase
            end
        end else if (ctrl.query && hold_fire) begin
            stamp_next     = now_ms;
            repeating_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_UNPRESSED;
            stamp_reg     <= '0;
            repeating_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            stamp_reg     <= stamp_next;
            repeating_reg <= repeating_next;
        end
    end

endmodule

FILE: hw/rtl/key_typematic_repeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_typematic_repeat_core: keyboard press tracker with auto-repeat
// Tracks the phase of every key from poll transfers and answers query
// transfers with whether a key fires now, including typematic repeats.
// ----------------------------------------------------------------------------
// The core takes one transfer per clock cycle on the s_ channel while the
// output is not stalled, and returns exactly one result transfer per input
// on the m_ channel, through the input register and then the result
// register, with a single pass of per-key logic between them, where every
// key cell updates in parallel. A poll transfer (command 0) carries the
// level of every key and advances each key from unpressed to pressed, to
// hold while still down, and through released back to unpressed once let
// go; its result is all zero. A query transfer (command 1) reports the phase
// of one key and whether it fires now: a pressed key always fires, and a
// held key outside the edge-only mask fires once the wrapping millisecond
// time since its stamp reaches the armed delay, which re-stamps the key and
// arms the repeat interval. Queries for a key index beyond the number of
// keys return zero and change nothing. The user writes the configuration
// registers (initial delay, repeat interval, edge-only mask) through the
// cfg_ port, only while the core is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module key_typematic_repeat_core import ktr_pkg::*; #(
    parameter int unsigned NUM_KEYS = NUM_KEYS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  ktr_in_t                s_item,

    output logic                   m_valid,
    input  logic                   m_ready,
    output ktr_out_t               m_item,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0]      initial_delay_reg;
    logic [DELAY_W-1:0]      repeat_interval_reg;
    logic [KEY_LEVELS_W-1:0] edge_only_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_delay_reg   <= INITIAL_DELAY_RESET;
            repeat_interval_reg <= REPEAT_INTERVAL_RESET;
            edge_only_mask_reg  <= EDGE_ONLY_MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INITIAL_DELAY: begin
                    initial_delay_reg <= cfg_wdata[DELAY_W-1:0];
                end
                CFG_REPEAT_INTERVAL: begin
                    repeat_interval_reg <= cfg_wdata[DELAY_W-1:0];
                end
                CFG_EDGE_ONLY_MASK: begin
                    edge_only_mask_reg <= cfg_wdata[KEY_LEVELS_W-1:0];
                end
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. It refills in the same cycle that its item moves on,
    // so a transfer can be accepted every cycle while the output drains.
    // ------------------------------------------------------------------
    logic    in_valid_reg;
    ktr_in_t in_item_reg;
    logic    out_valid_reg;
    ktr_out_t out_item_reg, out_item_next;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // ------------------------------------------------------------------
    // Key cells. Each cell compares the query index against its own
    // number, so an index with no matching cell simply selects nothing.
    // Keys beyond the level field always see a low level and never belong
    // to the edge-only mask.
    // ------------------------------------------------------------------
    logic          is_poll;
    logic          is_query;
    logic [NUM_KEYS-1:0] key_sel;
    ktr_key_ctrl_t key_ctrl [NUM_KEYS];
    ktr_key_stat_t key_stat [NUM_KEYS];

    assign is_poll  = (in_item_reg.command == CMD_POLL);
    assign is_query = (in_item_reg.command == CMD_QUERY);

    for (genvar gi = 0; gi < NUM_KEYS; gi++) begin : g_key
        logic key_level;
        logic key_edge_only;

        if (gi < (2 ** KEY_INDEX_W)) begin : g_sel
            assign key_sel[gi] = (in_item_reg.key_index == KEY_INDEX_W'(gi));
        end else begin : g_nosel
            assign key_sel[gi] = 1'b0;
        end

        if (gi < KEY_LEVELS_W) begin : g_lvl
            assign key_level     = in_item_reg.key_levels[gi];
            assign key_edge_only = edge_only_mask_reg[gi];
        end else begin : g_nolvl
            assign key_level     = 1'b0;
            assign key_edge_only = 1'b0;
        end

        assign key_ctrl[gi].poll      = advance && is_poll;
        assign key_ctrl[gi].query     = advance && is_query && key_sel[gi];
        assign key_ctrl[gi].level     = key_level;
        assign key_ctrl[gi].edge_only = key_edge_only;

        ktr_key_cell u_key_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .ctrl            (key_ctrl[gi]),
            .now_ms          (in_item_reg.now_ms),
            .initial_delay   (initial_delay_reg),
            .repeat_interval (repeat_interval_reg),
            .stat            (key_stat[gi])
        );
    end

    // ------------------------------------------------------------------
    // Result selection. At most one key is selected, so an OR across the
    // cells picks its status; poll results are forced to zero.
    // ------------------------------------------------------------------
    always_comb begin
        logic       active_any;
        logic [1:0] phase_any;
        active_any = 1'b0;
        phase_any  = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (key_sel[i]) begin
                active_any = active_any | key_stat[i].fire;
                phase_any  = phase_any | key_stat[i].phase;
            end
        end
        out_item_next.key_active = is_query && active_any;
        out_item_next.key_phase  = is_query ? phase_any : 2'b00;
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

FILE: hw/rtl/ktr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktr_checker: port-level checks for the typematic repeat core
// Watches the ports of the core over time and is bound to every instance.
// ----------------------------------------------------------------------------
module ktr_checker import ktr_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input ktr_out_t               m_item
);

    // Reset empties the result register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result side empty, nothing can hold back the input side.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // An offered input is only held off while a result waits for the receiver.
    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // Only a pressed or held key can fire.
    a_fire_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.key_active |->
            (m_item.key_phase == PH_PRESSED) || (m_item.key_phase == PH_HOLD))
        else $error("key fires in a phase that never fires");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

endmodule

bind key_typematic_repeat_core ktr_checker u_ktr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

FILE: test/key_answer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_answer_checker: predicts and checks the answers of the repeat core
// Tracks the phase, stamp and repeat state of every key from the accepted
// input transfers and register writes, and compares each result transfer
// field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module key_answer_checker import ktr_pkg::*; #(
    parameter int unsigned NUM_KEYS = NUM_KEYS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  ktr_in_t                s_item,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  ktr_out_t               m_item,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     outstanding
);

    logic [DELAY_W-1:0]      initial_delay;
    logic [DELAY_W-1:0]      repeat_interval;
    logic [KEY_LEVELS_W-1:0] edge_only;

    ktr_phase_t        phase_of  [NUM_KEYS];
    logic [TIME_W-1:0] stamp_of  [NUM_KEYS];
    logic              repeating [NUM_KEYS];

    ktr_out_t pending_answers [$];

    // Advances the key table by one input transfer and returns its answer.
    function automatic ktr_out_t track_keys(input ktr_in_t it);
        ktr_out_t          ans;
        logic [TIME_W-1:0] armed;
        logic              down;
        int unsigned       k;
        ans = '0;
        if (it.command == CMD_POLL) begin
            for (int unsigned i = 0; i < NUM_KEYS; i++) begin
                down = (i < KEY_LEVELS_W) ? it.key_levels[i] : 1'b0;
                if (down) begin
                    if (phase_of[i] == PH_UNPRESSED) begin
                        stamp_of[i]  = it.now_ms;
                        repeating[i] = 1'b0;
                        phase_of[i]  = PH_PRESSED;
                    end else begin
                        phase_of[i] = PH_HOLD;
                    end
                end else if (phase_of[i] == PH_PRESSED || phase_of[i] == PH_HOLD) begin
                    phase_of[i] = PH_RELEASED;
                end else begin
                    phase_of[i] = PH_UNPRESSED;
                end
            end
        end else if (it.key_index < NUM_KEYS) begin
            k = 32'(it.key_index);
            ans.key_phase = phase_of[k];
            case (phase_of[k])
                PH_PRESSED: begin
                    ans.key_active = 1'b1;
                end
                PH_HOLD: begin
                    // Keys in the edge-only mask never repeat.
                    if (!(k < KEY_LEVELS_W && edge_only[k])) begin
                        armed = TIME_W'(repeating[k] ? repeat_interval : initial_delay);
                        if (TIME_W'(it.now_ms - stamp_of[k]) >= armed) begin
                            stamp_of[k]    = it.now_ms;
                            repeating[k]   = 1'b1;
                            ans.key_active = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        return ans;
    endfunction

    always @(posedge aclk) begin : watch
        ktr_out_t want;
        if (!aresetn) begin
            initial_delay   = INITIAL_DELAY_RESET;
            repeat_interval = REPEAT_INTERVAL_RESET;
            edge_only       = EDGE_ONLY_MASK_RESET;
            for (int unsigned i = 0; i < NUM_KEYS; i++) begin
                phase_of[i]  = PH_UNPRESSED;
                stamp_of[i]  = '0;
                repeating[i] = 1'b0;
            end
            pending_answers.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INITIAL_DELAY:   initial_delay   = cfg_wdata[DELAY_W-1:0];
                    CFG_REPEAT_INTERVAL: repeat_interval = cfg_wdata[DELAY_W-1:0];
                    CFG_EDGE_ONLY_MASK:  edge_only       = cfg_wdata[KEY_LEVELS_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t ns: result transfer with no answer expected, got %0b/%0d",
                             $time, m_item.key_active, m_item.key_phase);
                    fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_item.key_active !== want.key_active) begin
                        $display("%0t ns: key_active mismatch, expected %0b, got %0b",
                                 $time, want.key_active, m_item.key_active);
                        fail_count++;
                    end
                    if (m_item.key_phase !== want.key_phase) begin
                        $display("%0t ns: key_phase mismatch, expected %0d, got %0d",
                                 $time, want.key_phase, m_item.key_phase);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_answers.push_back(track_keys(s_item));
            end
        end
        outstanding = pending_answers.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the typematic repeat core
// Drives poll and query transfers and register writes into the core, with
// random idling on both channels, and leaves prediction and checking to the
// answer checker that sits beside the core.
// ----------------------------------------------------------------------------
module testbench;
    import ktr_pkg::*;

    localparam int unsigned NUM_KEYS        = NUM_KEYS_DEFAULT;
    // Margin for the core to settle before the verdict.
    localparam int unsigned SETTLE_CYCLES   = 8;
    // Receiver hold-off long enough to fill every register of the core.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // Cycles without any transfer before the run is declared hung. The
    // longest legal gap is the hold-off above, so this leaves ample room.
    localparam int unsigned STALL_LIMIT     = 5000;
    // Register index that the core does not implement; writes must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn;

    logic     s_valid;
    logic     s_ready;
    ktr_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    ktr_out_t m_item;

    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int fail_count;
    int outstanding;

    // Idle percentages of each side, changed between phases.
    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 57;

    // Hold-off request from the stimulus; the receiver process answers it once.
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;

    // Running millisecond clock and the keys currently held by the random part.
    logic [TIME_W-1:0]       clock_ms;
    logic [KEY_LEVELS_W-1:0] held_keys;

    int unsigned quiet_cycles = 0;

    always #10 aclk = ~aclk;

    key_typematic_repeat_core #(
        .NUM_KEYS (NUM_KEYS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    key_answer_checker #(
        .NUM_KEYS (NUM_KEYS)
    ) answer_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog: any transfer on either channel clears the count. A core that
    // stops answering, or stops taking transfers, ends the run here.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver. It drops ready at random according to its idle percentage,
    // and once, on request, holds ready low for a long stretch so that the
    // core fills up and has to stall its input while the sender keeps going.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offers one transfer, after an optional random idle gap, and returns at
    // the falling edge after it has been accepted. Valid is left high so that
    // back-to-back transfers do not see a dip; the caller lowers it at the end.
    task automatic send_item(input ktr_in_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Waits until every predicted answer has arrived, then lets the core's
    // pipeline settle. The sender must already have lowered valid.
    task automatic wait_for_answers();
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Writes all three registers back to back, optionally followed by a
    // write to the unimplemented index, which must change nothing.
    task automatic load_registers(input logic [DELAY_W-1:0] delay,
                                  input logic [DELAY_W-1:0] interval,
                                  input logic [KEY_LEVELS_W-1:0] mask,
                                  input bit poke_unused);
        logic [CFG_DATA_W-KEY_LEVELS_W-1:0] pad;
        pad = (CFG_DATA_W-KEY_LEVELS_W)'($urandom());
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_INITIAL_DELAY;
        cfg_wdata <= delay;
        @(negedge aclk);
        cfg_index <= CFG_REPEAT_INTERVAL;
        cfg_wdata <= interval;
        @(negedge aclk);
        // Bits above the mask width are junk and must be dropped by the core.
        cfg_index <= CFG_EDGE_ONLY_MASK;
        cfg_wdata <= {pad, mask};
        @(negedge aclk);
        if (poke_unused) begin
            cfg_index <= CFG_UNUSED;
            cfg_wdata <= CFG_DATA_W'($urandom());
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic ktr_in_t poll_at(input logic [KEY_LEVELS_W-1:0] levels,
                                        input logic [TIME_W-1:0] now);
        ktr_in_t it;
        it.command    = CMD_POLL;
        it.key_levels = levels;
        it.key_index  = KEY_INDEX_W'($urandom());
        it.now_ms     = now;
        return it;
    endfunction

    function automatic ktr_in_t query_at(input logic [KEY_INDEX_W-1:0] idx,
                                         input logic [TIME_W-1:0] now);
        ktr_in_t it;
        it.command    = CMD_QUERY;
        it.key_levels = KEY_LEVELS_W'($urandom());
        it.key_index  = idx;
        it.now_ms     = now;
        return it;
    endfunction

    // Next random transfer. Keys are mostly held for a while and let go at
    // random, so that holds last long enough for repeats to come due, and
    // time creeps forward in small steps with an occasional large jump
    // (across the repeat delay, or anywhere at all, wrapping included).
    function automatic ktr_in_t next_key_event(input int unsigned step_max,
                                               input int unsigned jump_pct);
        ktr_in_t     it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < jump_pct) begin
            if ($urandom_range(0, 1) == 0) begin
                clock_ms += $urandom_range(60000, 70000);
            end else begin
                clock_ms = $urandom();
            end
        end else begin
            clock_ms += $urandom_range(0, step_max);
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            if (roll < 3) begin
                held_keys = KEY_LEVELS_W'($urandom());
            end else begin
                for (int i = 0; i < KEY_LEVELS_W; i++) begin
                    if ($urandom_range(0, 5) == 0) held_keys[i] = ~held_keys[i];
                end
            end
            it = poll_at(held_keys, clock_ms);
        end else if ($urandom_range(0, 99) < 90) begin
            it = query_at(KEY_INDEX_W'($urandom_range(0, NUM_KEYS - 1)), clock_ms);
        end else begin
            // Key indices past the last key must be answered with zero.
            it = query_at(KEY_INDEX_W'($urandom_range(NUM_KEYS, (1 << KEY_INDEX_W) - 1)),
                          clock_ms);
        end
        return it;
    endfunction

    // A phase of random transfers. At transfer number pause_at the sender
    // stops and waits for every outstanding answer before it carries on.
    task automatic run_keys(input int unsigned count, input int unsigned step_max,
                            input int unsigned jump_pct, input int unsigned pause_at);
        for (int unsigned n = 0; n < count; n++) begin
            if (n == pause_at) begin
                s_valid <= 1'b0;
                wait_for_answers();
            end
            send_item(next_key_event(step_max, jump_pct));
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_INITIAL_DELAY;
        cfg_wdata = '0;
        clock_ms  = $urandom();
        held_keys = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, with the reset register values (250 ms first delay,
        // 33 ms repeat interval, no edge-only keys).
        send_item(query_at(KEY_INDEX_W'(0), 32'h0000_0000));   // idle key answers zero
        send_item(poll_at('1, 32'd100));                       // every key goes down
        send_item(query_at(KEY_INDEX_W'(0), 32'd100));         // first press fires
        send_item(query_at(KEY_INDEX_W'(NUM_KEYS - 1), 32'd100)); // so does the last key
        send_item(query_at(KEY_INDEX_W'(NUM_KEYS), 32'd100));  // first index past the keys
        send_item(query_at('1, 32'hFFFF_FFFF));                // highest index, latest time
        send_item(poll_at('1, 32'd200));                       // still down: hold
        send_item(query_at(KEY_INDEX_W'(3), 32'd349));         // one short of the first delay
        send_item(query_at(KEY_INDEX_W'(3), 32'd350));         // first repeat, re-stamps
        send_item(query_at(KEY_INDEX_W'(3), 32'd382));         // one short of the interval
        send_item(query_at(KEY_INDEX_W'(3), 32'd383));         // second repeat
        send_item(poll_at(13'h0AAA, 32'd400));                 // even keys let go: released
        send_item(query_at(KEY_INDEX_W'(0), 32'd400));         // released never fires
        send_item(query_at(KEY_INDEX_W'(1), 32'd400));         // held since 100, first repeat
        // A press straight after release goes to hold, keeping the old stamp.
        send_item(poll_at('1, 32'd410));
        send_item(query_at(KEY_INDEX_W'(0), 32'd410));
        send_item(poll_at('0, 32'd420));                       // all released
        send_item(poll_at('0, 32'd430));                       // and back to unpressed
        send_item(query_at(KEY_INDEX_W'(7), 32'd430));
        // Elapsed time across the wrap of the millisecond counter.
        send_item(poll_at(13'h0020, 32'hFFFF_FF00));
        send_item(poll_at(13'h0020, 32'hFFFF_FF80));
        send_item(query_at(KEY_INDEX_W'(5), 32'h0000_0010));   // 272 ms after the press
        send_item(query_at(KEY_INDEX_W'(5), 32'h0000_0030));   // 32 ms: not yet
        send_item(query_at(KEY_INDEX_W'(5), 32'h0000_0031));   // 33 ms: repeats
        send_item(poll_at('0, 32'hFFFF_FFFF));
        s_valid <= 1'b0;
        wait_for_answers();

        // Short delays with every other key edge-only; the sender also
        // pauses once mid-phase until the core has answered everything.
        load_registers(16'd20, 16'd7, 13'h1555, 1'b0);
        run_keys(250, 6, 3, 120);
        wait_for_answers();

        // Longest delays; the large time jumps are what make repeats happen.
        send_idle_pct = 57;
        recv_idle_pct = 14;
        load_registers('1, '1, '0, 1'b0);
        run_keys(150, 20, 15, 150);
        wait_for_answers();

        // Zero delays with every key edge-only, so no key ever repeats.
        load_registers('0, '0, '1, 1'b0);
        run_keys(150, 3, 3, 150);
        wait_for_answers();

        // Random registers plus a write to the unused index; no idling, and
        // the receiver holds off for a long stretch at the start.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_registers(DELAY_W'($urandom_range(0, 40)), DELAY_W'($urandom_range(0, 15)),
                       KEY_LEVELS_W'($urandom()), 1'b1);
        hold_off_req = 1'b1;
        run_keys(200, 8, 3, 200);
        wait_for_answers();

        // Back to the reset values with time moving in larger steps.
        load_registers(INITIAL_DELAY_RESET, REPEAT_INTERVAL_RESET, EDGE_ONLY_MASK_RESET, 1'b0);
        run_keys(200, 40, 3, 200);
        wait_for_answers();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
